// ===== hw/rtl/http_request_header_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the HTTP request header scanner
// Each macro expands to one labeled concurrent assertion on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_SCANNER_MACROS_SVH
`define HTTP_REQUEST_HEADER_SCANNER_MACROS_SVH

// Condition holds at every edge outside reset.
`define HRHS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HRHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hrhs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhs_pkg
// Types and codes shared by the HTTP request header scanner.
// ----------------------------------------------------------------------------
package hrhs_pkg;

  // Input request: one raw header byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } byte_item_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  method;
    logic [2:0]  status;
    logic [12:0] key_length;
    logic [12:0] value_length;
    logic [15:0] line_offset;
    logic [5:0]  header_index;
    logic        last;
  } result_t;

  // Result kinds
  localparam logic [1:0] KIND_REQ = 2'd0;
  localparam logic [1:0] KIND_HDR = 2'd1;
  localparam logic [1:0] KIND_SUM = 2'd2;

  // Method codes; METH_BAD is internal only
  localparam logic [2:0] METH_NONE  = 3'd0;
  localparam logic [2:0] METH_GET   = 3'd1;
  localparam logic [2:0] METH_PUT   = 3'd2;
  localparam logic [2:0] METH_POST  = 3'd3;
  localparam logic [2:0] METH_HEAD  = 3'd4;
  localparam logic [2:0] METH_PATCH = 3'd5;
  localparam logic [2:0] METH_BAD   = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_METH = 3'd1;
  localparam logic [2:0] ST_NO_REQ   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_TOO_MANY = 3'd4;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Method names, first character in the top byte
  localparam logic [23:0] STR_GET   = "GET";
  localparam logic [23:0] STR_PUT   = "PUT";
  localparam logic [31:0] STR_POST  = "POST";
  localparam logic [31:0] STR_HEAD  = "HEAD";
  localparam logic [39:0] STR_PATCH = "PATCH";

  // Scan phase
  typedef enum logic [2:0] {
    PH_REQ = 3'b001,
    PH_HDR = 3'b010,
    PH_IGN = 3'b100
  } phase_t;

endpackage

// ===== hw/rtl/http_request_header_scanner.sv =====
// Output: each result is registered in the result queue.
// Throughput: one byte per cycle while two queue slots are free; a byte
// that causes two results (a line result plus the frame summary) pushes
// both at once into the four-entry result queue.
// Reset: synchronous; clears the scan state and empties the result queue.
// ----------------------------------------------------------------------------
// http_request_header_scanner
// Splits request header bytes into lines, decodes the method from the request
// line, reports key/value lengths of header lines and a per-frame summary.
// ----------------------------------------------------------------------------
`include "http_request_header_scanner_macros.svh"

module http_request_header_scanner
  import hrhs_pkg::*;
#(
  parameter int MAX_LINE    = 4096,
  parameter int MAX_HEADERS = 32,
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_data,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result_data
);

  localparam int LEN_W = $clog2(MAX_LINE + 2);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Scan state
  phase_t                 phase, phase_next;
  logic                   cr_seen, cr_seen_next;
  logic [LEN_W-1:0]       line_bytes, line_bytes_next;
  logic [4:0][7:0]        method_prefix, method_prefix_next;
  logic [2:0]             method_code, method_code_next;
  logic [LEN_W-1:0]       colon_position, colon_position_next;
  logic                   colon_seen, colon_seen_next;
  logic [5:0]             header_count, header_count_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] line_offset_reg, line_offset_reg_next;
  logic [2:0]             frame_status, frame_status_next;

  // Result queue
  result_t               queue [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]     count;

  logic                  accept, pop;
  logic [7:0]            b;
  logic                  fe;
  logic [OFFSET_BITS-1:0] offset_step;
  logic [2:0]            decided;
  logic [2:0]            fmeth, fmeth_next;
  logic                  line_emit;
  result_t               line_res, sum_res;
  logic [LEN_W:0]        val_diff;
  logic [LEN_W-1:0]      val_len;
  logic [15:0]           key_wide, val_wide;
  logic [31:0]           off_wide;
  logic [2:0]            sum_status;
  logic                  long_line;

  assign accept = byte_valid && byte_ready;
  assign pop    = result_valid && result_ready;
  assign b      = byte_data.data_byte;
  assign fe     = byte_data.frame_end;

  assign offset_step = (byte_offset == {OFFSET_BITS{1'b1}}) ? byte_offset
                                                             : byte_offset + 1'b1;
  assign long_line = line_bytes > LEN_W'(MAX_LINE);

  // Method from the space position and the stored prefix
  always_comb begin
    decided = METH_BAD;
    if (line_bytes == LEN_W'(3)) begin
      if ({method_prefix[0], method_prefix[1], method_prefix[2]} == STR_GET) begin
        decided = METH_GET;
      end else if ({method_prefix[0], method_prefix[1], method_prefix[2]} == STR_PUT) begin
        decided = METH_PUT;
      end
    end else if (line_bytes == LEN_W'(4)) begin
      if ({method_prefix[0], method_prefix[1], method_prefix[2],
           method_prefix[3]} == STR_POST) begin
        decided = METH_POST;
      end else if ({method_prefix[0], method_prefix[1], method_prefix[2],
                    method_prefix[3]} == STR_HEAD) begin
        decided = METH_HEAD;
      end
    end else if (line_bytes == LEN_W'(5)) begin
      if ({method_prefix[0], method_prefix[1], method_prefix[2],
           method_prefix[3], method_prefix[4]} == STR_PATCH) begin
        decided = METH_PATCH;
      end
    end
  end

  assign fmeth = (method_code >= METH_GET && method_code <= METH_PATCH) ? method_code
                                                                        : METH_NONE;

  // Value length: bytes after colon and one space, floored at zero
  assign val_diff = {1'b0, line_bytes} - {1'b0, colon_position} - (LEN_W+1)'(2);
  assign val_len  = ({1'b0, line_bytes} >= {1'b0, colon_position} + (LEN_W+1)'(2))
                    ? val_diff[LEN_W-1:0] : '0;
  assign key_wide = 16'(colon_position);
  assign val_wide = 16'(val_len);
  assign off_wide = 32'(line_offset_reg);

  // Next state and line result
  always_comb begin
    phase_next           = phase;
    cr_seen_next         = cr_seen;
    line_bytes_next      = line_bytes;
    method_prefix_next   = method_prefix;
    method_code_next     = method_code;
    colon_position_next  = colon_position;
    colon_seen_next      = colon_seen;
    header_count_next    = header_count;
    line_offset_reg_next = line_offset_reg;
    frame_status_next    = frame_status;
    line_emit            = 1'b0;
    line_res             = '0;
    line_res.line_offset = off_wide[15:0];
    line_res.last        = !fe;

    unique case (phase)
      PH_REQ: begin
        if (b == CH_CR) begin
          cr_seen_next = 1'b1;
        end else if (b == CH_LF) begin
          if (cr_seen) begin
            line_emit     = 1'b1;
            line_res.kind = KIND_REQ;
            if (long_line) begin
              line_res.status = ST_TOO_LONG;
            end else if (fmeth != METH_NONE) begin
              line_res.status = ST_OK;
              line_res.method = fmeth;
            end else begin
              line_res.status = ST_BAD_METH;
            end
            if (line_res.status == ST_OK) begin
              phase_next = PH_HDR;
            end else begin
              if (frame_status == ST_OK) frame_status_next = line_res.status;
              phase_next = PH_IGN;
            end
            line_bytes_next      = '0;
            cr_seen_next         = 1'b0;
            colon_seen_next      = 1'b0;
            colon_position_next  = '0;
            line_offset_reg_next = offset_step;
          end
        end else begin
          cr_seen_next = 1'b0;
          if (b == CH_SPACE && line_bytes != '0 && method_code == METH_NONE) begin
            method_code_next = decided;
          end
          if (line_bytes < LEN_W'(5)) begin
            method_prefix_next[line_bytes[2:0]] = b;
          end
          if (!long_line) line_bytes_next = line_bytes + 1'b1;
        end
      end
      PH_HDR: begin
        if (b == CH_CR) begin
          cr_seen_next = 1'b1;
        end else if (b == CH_LF) begin
          if (cr_seen) begin
            line_res.kind         = KIND_HDR;
            line_res.method       = fmeth;
            line_res.header_index = header_count;
            if (long_line) begin
              line_emit       = 1'b1;
              line_res.status = ST_TOO_LONG;
              if (frame_status == ST_OK) frame_status_next = ST_TOO_LONG;
            end else if (colon_seen) begin
              line_emit             = 1'b1;
              line_res.key_length   = key_wide[12:0];
              line_res.value_length = val_wide[12:0];
              if (header_count >= 6'(MAX_HEADERS)) begin
                line_res.status = ST_TOO_MANY;
                if (frame_status == ST_OK) frame_status_next = ST_TOO_MANY;
              end else begin
                line_res.status   = ST_OK;
                header_count_next = header_count + 1'b1;
              end
            end
          end
          // A bare LF ends the line too
          line_bytes_next      = '0;
          cr_seen_next         = 1'b0;
          colon_seen_next      = 1'b0;
          colon_position_next  = '0;
          line_offset_reg_next = offset_step;
        end else begin
          cr_seen_next = 1'b0;
          if (b == CH_COLON && !colon_seen) begin
            colon_seen_next     = 1'b1;
            colon_position_next = line_bytes;
          end
          if (!long_line) line_bytes_next = line_bytes + 1'b1;
        end
      end
      PH_IGN: begin
        // drop bytes until the frame ends
      end
      default: begin
        phase_next = PH_IGN;
      end
    endcase

    byte_offset_next = offset_step;

    // Summary from the updated state, then back to reset
    fmeth_next = (method_code_next >= METH_GET && method_code_next <= METH_PATCH)
                 ? method_code_next : METH_NONE;
    sum_status = (frame_status_next == ST_OK && phase_next == PH_REQ) ? ST_NO_REQ
                                                                     : frame_status_next;
    sum_res              = '0;
    sum_res.kind         = KIND_SUM;
    sum_res.method       = fmeth_next;
    sum_res.status       = sum_status;
    sum_res.header_index = header_count_next;
    sum_res.last         = 1'b1;

    if (fe) begin
      phase_next           = PH_REQ;
      cr_seen_next         = 1'b0;
      line_bytes_next      = '0;
      method_prefix_next   = '0;
      method_code_next     = METH_NONE;
      colon_position_next  = '0;
      colon_seen_next      = 1'b0;
      header_count_next    = '0;
      byte_offset_next     = '0;
      line_offset_reg_next = '0;
      frame_status_next    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_REQ;
      cr_seen         <= 1'b0;
      line_bytes      <= '0;
      method_prefix   <= '0;
      method_code     <= METH_NONE;
      colon_position  <= '0;
      colon_seen      <= 1'b0;
      header_count    <= '0;
      byte_offset     <= '0;
      line_offset_reg <= '0;
      frame_status    <= ST_OK;
    end else if (accept) begin
      phase           <= phase_next;
      cr_seen         <= cr_seen_next;
      line_bytes      <= line_bytes_next;
      method_prefix   <= method_prefix_next;
      method_code     <= method_code_next;
      colon_position  <= colon_position_next;
      colon_seen      <= colon_seen_next;
      header_count    <= header_count_next;
      byte_offset     <= byte_offset_next;
      line_offset_reg <= line_offset_reg_next;
      frame_status    <= frame_status_next;
    end
  end

  // Result queue: push up to two per request, pop one per cycle on result_ready
  logic [1:0]        push_cnt;
  logic [QPTR_W-1:0] wr_ptr_1;

  assign push_cnt = accept ? ({1'b0, line_emit} + {1'b0, fe}) : 2'd0;
  assign wr_ptr_1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (accept) begin
      if (line_emit) begin
        queue[wr_ptr] <= line_res;
        if (fe) queue[wr_ptr_1] <= sum_res;
      end else if (fe) begin
        queue[wr_ptr] <= sum_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_cnt);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end
  end

  // Hold off new bytes unless two slots are free
  assign byte_ready   = count <= QCNT_W'(QDEPTH - 2);
  assign result_valid = count != '0;
  assign result_data  = queue[rd_ptr];

  `HRHS_ASSERT_ALWAYS(a_queue_bound, count <= QCNT_W'(QDEPTH), "result queue overflow")
  `HRHS_ASSERT_ALWAYS(a_hdr_bound, header_count <= 6'(MAX_HEADERS), "header count over limit")
  `HRHS_ASSERT_NEXT(a_frame_reset, accept && fe,
    phase == PH_REQ && header_count == '0 && byte_offset == '0 && count != '0,
    "frame end did not reset the scanner")

endmodule
